// ===== rtl/mrpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrpt_pkg: shared constants for the miller-rabin prime test
// witness bases and default sizes
// ----------------------------------------------------------------------------
package mrpt_pkg;
	localparam int NUM_BASES_DEF    = 12;
	localparam int NUMBER_WIDTH_DEF = 64;
	localparam int MAX_BASES        = 12;
	localparam int BASE_W           = 6;

	function automatic logic [BASE_W-1:0] witness_base(input logic [3:0] k);
		logic [BASE_W-1:0] b;
		unique case (k)
			4'd0:    b = 6'd2;
			4'd1:    b = 6'd3;
			4'd2:    b = 6'd5;
			4'd3:    b = 6'd7;
			4'd4:    b = 6'd11;
			4'd5:    b = 6'd13;
			4'd6:    b = 6'd17;
			4'd7:    b = 6'd19;
			4'd8:    b = 6'd23;
			4'd9:    b = 6'd29;
			4'd10:   b = 6'd31;
			4'd11:   b = 6'd37;
			default: b = 6'd37;
		endcase
		return b;
	endfunction
endpackage

// ===== rtl/mrpt_mulmod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrpt_mulmod: shift-and-add modular multiplier
// one bit of the multiplier per cycle, operands below the modulus
// ----------------------------------------------------------------------------
module mrpt_mulmod
	import mrpt_pkg::*;
#(
	parameter int W = NUMBER_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] x,
	input  logic [W-1:0] y,
	input  logic [W-1:0] m,
	output logic         done,
	output logic [W-1:0] prod
);
	localparam int CW = $clog2(W);

	logic         busy_q;
	logic [CW-1:0] bit_q;
	logic [W-1:0] acc_q, x_q, y_q, m_q;
	logic [W:0]   dbl, dbl_r, add, add_r;
	logic [W-1:0] acc_n;

	always_comb begin
		dbl   = {acc_q, 1'b0};
		dbl_r = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
		add   = dbl_r + {1'b0, x_q};
		add_r = (add >= {1'b0, m_q}) ? add - {1'b0, m_q} : add;
		acc_n = y_q[bit_q] ? add_r[W-1:0] : dbl_r[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			bit_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				bit_q  <= CW'(W - 1);
			end else if (busy_q) begin
				if (bit_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end else begin
					bit_q <= bit_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			x_q   <= x;
			y_q   <= y;
			m_q   <= m;
		end else if (busy_q) begin
			acc_q <= acc_n;
		end
	end

	assign prod = acc_q;
endmodule

// ===== rtl/miller_rabin_prime_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// miller_rabin_prime_test: deterministic miller-rabin primality test
// one number in, one prime flag out
// ----------------------------------------------------------------------------
// A number is taken on the slave side when the block is idle; tready stays low
// until the flag is out. n-1 is split into 2^r*d by shifting one bit a cycle,
// then each witness base runs a right-to-left square-and-multiply on a^d mod n
// followed by up to r-1 squarings. Every modular product goes through one
// shift-and-add multiplier. A prime runs every base up to n-2, a composite
// stops at the first base that it fails, and numbers below four need no
// product at all. The result register holds the flag until taken.
module miller_rabin_prime_test
	import mrpt_pkg::*;
#(
	parameter int NUM_BASES    = NUM_BASES_DEF,
	parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // [63:0] number
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // [0] is_prime, [7:1] zero
);
	localparam int W  = NUMBER_WIDTH;
	localparam int RW = $clog2(W + 1);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SPLIT = 4'd1;
	localparam logic [3:0] ST_BASE  = 4'd2;
	localparam logic [3:0] ST_PMUL  = 4'd3;
	localparam logic [3:0] ST_PWAIT = 4'd4;
	localparam logic [3:0] ST_PSQ   = 4'd5;
	localparam logic [3:0] ST_SWAIT = 4'd6;
	localparam logic [3:0] ST_CHK   = 4'd7;
	localparam logic [3:0] ST_SQ    = 4'd8;
	localparam logic [3:0] ST_QWAIT = 4'd9;
	localparam logic [3:0] ST_OUT   = 4'd10;

	logic [3:0]    state_q;
	logic [W-1:0]  n_q, d_q, e_q, acc_q, b_q;
	logic [RW-1:0] r_q, i_q;
	logic [3:0]    k_q;
	logic          res_q;

	logic          mm_start, mm_done;
	logic [W-1:0]  mm_x, mm_y, mm_p;
	logic [W-1:0]  nm1, a_ext;

	assign nm1   = n_q - 1'b1;
	assign a_ext = W'(witness_base(k_q));

	mrpt_mulmod #(.W(W)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mm_start),
		.x(mm_x), .y(mm_y), .m(n_q), .done(mm_done), .prod(mm_p)
	);

	always_comb begin
		mm_start = (state_q == ST_PMUL) || (state_q == ST_PSQ) || (state_q == ST_SQ);
		unique case (state_q)
			ST_PMUL: begin mm_x = acc_q; mm_y = b_q; end
			ST_PSQ:  begin mm_x = b_q;   mm_y = b_q; end
			default: begin mm_x = acc_q; mm_y = acc_q; end
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = {7'd0, res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			r_q     <= '0;
			i_q     <= '0;
			res_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (s_tvalid) begin
					// values below two are never prime
					if (s_tdata[W-1:0] < W'(2)) begin
						res_q   <= 1'b0;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_SPLIT;
					end
					r_q <= '0;
					k_q <= '0;
				end
				ST_SPLIT: begin
					if (d_q[0] == 1'b0) r_q <= r_q + 1'b1;
					else state_q <= ST_BASE;
				end
				ST_BASE: begin
					// scan ends at the last base, the first base above n-2, or n below four
					if (k_q == 4'(NUM_BASES) || a_ext > nm1 - 1'b1 || n_q < W'(4)) begin
						res_q   <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						state_q <= d_q[0] ? ST_PMUL : ST_PSQ;
					end
				end
				ST_PMUL:  state_q <= ST_PWAIT;
				ST_PWAIT: if (mm_done) state_q <= ST_PSQ;
				ST_PSQ:   state_q <= ST_SWAIT;
				ST_SWAIT: if (mm_done) begin
					// exponent is shifted at this edge, so look one bit ahead
					if (e_q[W-1:1] == '0) begin
						i_q     <= RW'(1);
						state_q <= ST_CHK;
					end else begin
						state_q <= e_q[1] ? ST_PMUL : ST_PSQ;
					end
				end
				ST_CHK: begin
					if (acc_q == nm1 || (i_q == RW'(1) && acc_q == W'(1))) begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_BASE;
					end else if (i_q >= r_q) begin
						res_q   <= 1'b0;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_SQ;
					end
				end
				ST_SQ:    state_q <= ST_QWAIT;
				ST_QWAIT: if (mm_done) begin
					i_q     <= i_q + 1'b1;
					state_q <= ST_CHK;
				end
				ST_OUT:   if (m_tready) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				n_q <= s_tdata[W-1:0];
				d_q <= s_tdata[W-1:0] - 1'b1;
			end
			ST_SPLIT: if (d_q[0] == 1'b0) d_q <= d_q >> 1;
			ST_BASE: begin
				e_q   <= d_q;
				acc_q <= W'(1);
				b_q   <= a_ext;
			end
			ST_PWAIT: if (mm_done) acc_q <= mm_p;
			ST_SWAIT: if (mm_done) begin
				b_q <= mm_p;
				e_q <= e_q >> 1;
			end
			ST_PSQ: ;
			ST_QWAIT: if (mm_done) acc_q <= mm_p;
			default: ;
		endcase
	end

	// result stays put while the master side stalls
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");
	// the multiplier is only started while a test is running
	a_mul_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mm_start |-> !s_tready && !m_tvalid)
		else $error("multiplier started outside a test");
	// no input is taken while a result waits
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("ready while result pending");
endmodule

// ===== tb/tb_miller_rabin_prime_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_miller_rabin_prime_test: self-checking bench for the prime test block
// a directed table of edge values and known pseudoprimes, then random numbers
// of mostly small bit lengths, each flag compared against a local primality
// predictor, with random idle cycles on both stream sides
// ----------------------------------------------------------------------------
module tb_miller_rabin_prime_test;
	import mrpt_pkg::*;

	localparam int NW          = NUMBER_WIDTH_DEF;
	localparam int RANDOM_NUMS = 300;
	localparam int STALL_LIMIT = 1000000;  // cycles with no transaction at all

	typedef struct {
		logic [63:0] number;
		bit          known;   // flag typed in below, else taken from predictor
		bit          flag;
	} vector_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;   // [63:0] number
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [0] is_prime, [7:1] zero

	bit          flag_queue[$];  // prime flags still owed by the block
	int          fail_count;
	int          flags_seen;
	int          primes_seen;
	int          idle_cycles;
	bit          quiet;          // no idling on either side while set
	bit          sending_done;

	vector_t     vectors[$];

	miller_rabin_prime_test i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor
	// exact modular product through a double-width intermediate
	function automatic logic [63:0] mod_product(logic [63:0] x, logic [63:0] y,
			logic [63:0] m);
		logic [127:0] p;
		p = {64'd0, x} * {64'd0, y};
		return 64'(p % {64'd0, m});
	endfunction

	function automatic logic [63:0] mod_power(logic [63:0] b, logic [63:0] e,
			logic [63:0] m);
		logic [63:0] acc;
		acc = 64'd1 % m;
		b = b % m;
		while (e != 0) begin
			if (e[0])
				acc = mod_product(acc, b, m);
			b = mod_product(b, b, m);
			e = e >> 1;
		end
		return acc;
	endfunction

	function automatic bit predict_prime(logic [63:0] raw);
		logic [63:0] n, d, x, a;
		int          r;
		bit          ok;
		n = raw & ((NW >= 64) ? '1 : ((64'd1 << NW) - 1));
		if (n < 2)
			return 1'b0;
		d = n - 1;
		r = 0;
		while (d != 0 && !d[0]) begin
			d = d >> 1;
			r++;
		end
		for (int k = 0; k < NUM_BASES_DEF && k < MAX_BASES; k++) begin
			a = 64'(witness_base(4'(k)));
			if (a > n - 2)
				break;
			x = mod_power(a, d, n);
			if (x == 1 || x == n - 1)
				continue;
			ok = 1'b0;
			for (int i = 1; i < r; i++) begin
				x = mod_product(x, x, n);
				if (x == n - 1) begin
					ok = 1'b1;
					break;
				end
			end
			if (!ok)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		fail_count++;
		$display("mismatch %0s: got %0h want %0h at %0t", what, got, want, $realtime);
	endtask

	// ----------------------------------------------------------------- stimulus
	function automatic logic [63:0] random_number();
		logic [63:0] v;
		int          w, pick;
		v = {$urandom, $urandom};
		pick = $urandom_range(99);
		// mostly short numbers, since a wide prime takes far longer to test
		if (pick < 70)      w = $urandom_range(10, 2);
		else if (pick < 95) w = $urandom_range(32, 11);
		else                w = $urandom_range(64, 33);
		if (w < 64)
			v = v & ((64'd1 << w) - 1);
		// odd values are the ones that reach the squaring chain
		if ($urandom_range(99) < 80)
			v[0] = 1'b1;
		return v;
	endfunction

	task automatic add_vector(logic [63:0] n, bit known, bit flag);
		vector_t v;
		v.number = n;
		v.known  = known;
		v.flag   = flag;
		vectors.push_back(v);
	endtask

	initial begin
		// edge values first, expected flag obvious
		add_vector(64'd0, 1, 0);
		add_vector(64'd1, 1, 0);
		add_vector(64'd2, 1, 1);
		add_vector(64'd3, 1, 1);
		add_vector(64'd4, 1, 0);
		add_vector(64'd5, 1, 1);
		add_vector(64'd37, 1, 1);
		add_vector(64'd38, 1, 0);
		add_vector(64'd41, 1, 1);
		add_vector(64'h8000_0000_0000_0000, 1, 0);
		add_vector(64'hFFFF_FFFF_FFFF_FFFF, 1, 0);        // divisible by three
		add_vector(64'hFFFF_FFFF_FFFF_FFC5, 1, 1);        // largest 64-bit prime
		// strong pseudoprimes, carmichael numbers and other values, checked by predictor
		add_vector(64'd2047, 0, 0);
		add_vector(64'd561, 0, 0);
		add_vector(64'd1373653, 0, 0);
		add_vector(64'd25326001, 0, 0);
		add_vector(64'd3215031751, 0, 0);
		add_vector(64'd341550071728321, 0, 0);
		add_vector(64'd3825123056546413051, 0, 0);
		add_vector(64'd4294967291, 0, 0);                 // largest 32-bit prime
		add_vector(64'hAAAA_AAAA_5555_5555, 0, 0);
		add_vector(64'h5555_5555_AAAA_AAAB, 0, 0);
		for (int i = 0; i < RANDOM_NUMS; i++)
			add_vector(random_number(), 0, 0);
	end

	// reset and sender
	initial begin
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		quiet        = 1'b0;
		sending_done = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < vectors.size(); i++) begin
			// a stretch of items with no idling on either side
			quiet = (i >= 120 && i < 170);
			@(negedge clk);
			while (!quiet && $urandom_range(99) < 20) begin
				s_tvalid <= 1'b0;
				@(negedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= vectors[i].number;
			do
				@(posedge clk);
			while (!s_tready);
			// transaction accepted at this edge
			if (vectors[i].known && vectors[i].flag != predict_prime(vectors[i].number))
				report_mismatch("table entry vs predictor",
					64'(predict_prime(vectors[i].number)), 64'(vectors[i].flag));
			flag_queue.push_back(vectors[i].known ? vectors[i].flag
				: predict_prime(vectors[i].number));
		end
		@(negedge clk);
		s_tvalid <= 1'b0;
		sending_done = 1'b1;
	end

	// receiver back-pressure
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready <= quiet || ($urandom_range(99) >= 20);
		end
	end

	// ------------------------------------------------------------------ checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			flags_seen++;
			if (flag_queue.size() == 0) begin
				report_mismatch("flag with nothing owed", 64'(m_tdata), 64'd0);
			end else begin
				bit want;
				want = flag_queue.pop_front();
				if (m_tdata[0] != want)
					report_mismatch("is_prime", 64'(m_tdata[0]), 64'(want));
				if (m_tdata[7:1] != 7'd0)
					report_mismatch("pad bits", 64'(m_tdata[7:1]), 64'd0);
				if (want)
					primes_seen++;
			end
		end
	end

	// watchdog: any transaction on either side restarts the count
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ---------------------------------------------------------------------- end
	initial begin
		fail_count  = 0;
		flags_seen  = 0;
		primes_seen = 0;
		idle_cycles = 0;
		wait (sending_done);
		while (flag_queue.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		$display("tested %0d numbers (%0d prime), table edges plus random widths",
			flags_seen, primes_seen);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/mrpt_pkg.sv
rtl/mrpt_mulmod.sv
rtl/miller_rabin_prime_test.sv
tb/tb_miller_rabin_prime_test.sv
